FILE: sv/sbs_pkg.sv
// sbs_pkg: shared types and constants of the wildcard byte signature scanner
// holds payload structs, match configuration struct and register indexes
// no dependencies
package sbs_pkg;

    // field and register widths
    localparam int SBS_ADDR_W        = 48;
    localparam int SBS_LEN_W         = 5;
    localparam int SBS_SKIP_W        = 4;
    localparam int SBS_CFG_W         = 64;
    localparam int SBS_CFG_IDX_W     = 3;
    localparam int SBS_PAT_REG_BYTES = 16;
    localparam int SBS_PAT_W         = 8 * SBS_PAT_REG_BYTES;

    // default window depth
    localparam int PATTERN_BYTES_DEF = 16;

    // register reset values
    localparam logic [SBS_PAT_REG_BYTES-1:0] SBS_CARE_RST = '1;
    localparam logic [SBS_LEN_W-1:0]         SBS_LEN_RST  = 5'd16;

    // configuration register indexes
    typedef enum logic [SBS_CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_CARE_MASK      = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_LEAD_SKIPS     = 3'd4,
        CFG_BASE_ADDRESS   = 3'd5
    } sbs_cfg_reg_t;

    // input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } sbs_in_t;

    // output transaction
    typedef struct packed {
        logic                  found;
        logic [SBS_ADDR_W-1:0] match_address;
    } sbs_out_t;

    // match settings shared by every cell
    typedef struct packed {
        logic [SBS_PAT_W-1:0]         pattern;
        logic [SBS_PAT_REG_BYTES-1:0] care;
        logic [SBS_LEN_W-1:0]         length;
    } sbs_match_cfg_t;

endpackage

FILE: sv/sbs_cell.sv
// sbs_cell: one window position of the scanner chain
// holds one byte, passes it on when shifting and extends the match chain
// depends on sbs_pkg
module sbs_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                    clk,
    input  logic                    shift_en,
    input  logic [7:0]              byte_in,
    output logic [7:0]              byte_out,
    input  logic                    match_in,
    output logic                    match_out,
    input  sbs_pkg::sbs_match_cfg_t cfg
);

    logic [7:0] byte_reg;
    logic       in_use;
    logic [3:0] pat_idx;
    logic [7:0] pat_byte;
    logic       byte_ok;

    // window byte, moves one cell further on each shift_en
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // this cell holds pattern byte length-1-index once the new byte is in
    always_comb
    begin
        in_use   = (CELL_INDEX < sbs_pkg::SBS_PAT_REG_BYTES)
                   && (int'(cfg.length) > CELL_INDEX);
        pat_idx  = 4'(cfg.length - 5'(CELL_INDEX) - 5'd1);
        pat_byte = cfg.pattern[{pat_idx, 3'b000} +: 8];
        byte_ok  = !in_use || !cfg.care[pat_idx] || (byte_in == pat_byte);
    end

    // compare against the value this cell takes on in this cycle
    assign match_out = match_in && byte_ok;

endmodule

FILE: sv/sbs_out_buf.sv
// sbs_out_buf: output register with one skid entry
// lets the scanner take input while a result waits on the output
// depends on sbs_pkg
module sbs_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  sbs_pkg::sbs_out_t push_data,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output sbs_pkg::sbs_out_t out_data
);

    logic              out_valid_reg;
    logic              out_valid_next;
    sbs_pkg::sbs_out_t out_data_reg;
    sbs_pkg::sbs_out_t out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    sbs_pkg::sbs_out_t skid_data_reg;
    sbs_pkg::sbs_out_t skid_data_next;
    logic              pop;

    assign pop      = out_valid_reg && out_ready;
    assign can_push = !skid_valid_reg;

    // next state of output and skid entries
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: sv/wildcard_byte_signature_scan.sv
// wildcard_byte_signature_scan: top level of the wildcard byte signature scanner
// chain of sbs_cell window positions, range control and sbs_out_buf output stage
// depends on sbs_pkg, sbs_cell, sbs_out_buf
//
//   channel   handshake             payload
//   -------   -------------------   ------------------------------------
//   input     in_valid / in_ready   in_data  (data_byte, last_byte)
//   output    out_valid / out_ready out_data (found, match_address)
//   config    cfg_we                cfg_index, cfg_data
//
// one byte per cycle while in_ready is high; a result goes to the output register, or to the skid entry while
// the output is held; the window compare runs through the cell chain in the cycle a byte is taken
// rst_n clears control state and loads register defaults; no clearing pass
// in_ready drops only when both the output register and the skid entry are full
module wildcard_byte_signature_scan #(
    parameter int PATTERN_BYTES = sbs_pkg::PATTERN_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sbs_pkg::sbs_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sbs_pkg::sbs_out_t                   out_data,
    input  logic                                cfg_we,
    input  logic [sbs_pkg::SBS_CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbs_pkg::SBS_CFG_W-1:0]       cfg_data
);

    localparam int FILL_W  = $clog2(PATTERN_BYTES + 1);
    localparam int LEN_CAP = (PATTERN_BYTES < sbs_pkg::SBS_PAT_REG_BYTES)
                             ? PATTERN_BYTES : sbs_pkg::SBS_PAT_REG_BYTES;

    // configuration registers
    logic [63:0]                         pattern_low_reg;
    logic [63:0]                         pattern_high_reg;
    logic [sbs_pkg::SBS_PAT_REG_BYTES-1:0] care_mask_reg;
    logic [sbs_pkg::SBS_LEN_W-1:0]       pattern_length_reg;
    logic [sbs_pkg::SBS_SKIP_W-1:0]      lead_skips_reg;
    logic [sbs_pkg::SBS_ADDR_W-1:0]      base_address_reg;

    // range state
    logic [sbs_pkg::SBS_ADDR_W-1:0]      position_reg;
    logic [sbs_pkg::SBS_ADDR_W-1:0]      position_next;
    logic [FILL_W-1:0]                   fill_reg;
    logic [FILL_W-1:0]                   fill_next;
    logic [FILL_W-1:0]                   fill_inc;
    logic                                reported_reg;
    logic                                reported_next;

    logic                                accept;
    logic                                shift_en;
    logic [sbs_pkg::SBS_LEN_W-1:0]       len_eff;
    logic [sbs_pkg::SBS_LEN_W-1:0]       addr_offset;
    sbs_pkg::sbs_match_cfg_t             match_cfg;
    logic                                window_hit;
    logic                                push_valid;
    sbs_pkg::sbs_out_t                   push_data;
    logic                                can_push;

    logic [7:0] chain_byte  [PATTERN_BYTES+1];
    logic       chain_match [PATTERN_BYTES+1];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= sbs_pkg::SBS_CARE_RST;
            pattern_length_reg <= sbs_pkg::SBS_LEN_RST;
            lead_skips_reg     <= '0;
            base_address_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (sbs_pkg::sbs_cfg_reg_t'(cfg_index))
                sbs_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                sbs_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                sbs_pkg::CFG_CARE_MASK:
                    care_mask_reg <= cfg_data[sbs_pkg::SBS_PAT_REG_BYTES-1:0];
                sbs_pkg::CFG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[sbs_pkg::SBS_LEN_W-1:0];
                sbs_pkg::CFG_LEAD_SKIPS:
                    lead_skips_reg <= cfg_data[sbs_pkg::SBS_SKIP_W-1:0];
                sbs_pkg::CFG_BASE_ADDRESS:
                    base_address_reg <= cfg_data[sbs_pkg::SBS_ADDR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // effective length and settings for the cells
    always_comb
    begin
        len_eff = (int'(pattern_length_reg) > LEN_CAP)
                  ? sbs_pkg::SBS_LEN_W'(LEN_CAP) : pattern_length_reg;
        match_cfg.pattern = {pattern_high_reg, pattern_low_reg};
        match_cfg.care    = care_mask_reg;
        match_cfg.length  = len_eff;
        addr_offset       = len_eff - 5'd1 + sbs_pkg::SBS_LEN_W'(lead_skips_reg);
    end

    assign accept   = in_valid && in_ready;
    assign shift_en = accept && !reported_reg;

    // window chain, newest byte enters cell 0
    assign chain_byte[0]  = in_data.data_byte;
    assign chain_match[0] = 1'b1;

    for (genvar k = 0; k < PATTERN_BYTES; k++)
    begin : g_cell
        sbs_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk       (clk),
            .shift_en  (shift_en),
            .byte_in   (chain_byte[k]),
            .byte_out  (chain_byte[k+1]),
            .match_in  (chain_match[k]),
            .match_out (chain_match[k+1]),
            .cfg       (match_cfg)
        );
    end

    // range control and result
    always_comb
    begin
        fill_inc   = (int'(fill_reg) == PATTERN_BYTES) ? fill_reg : fill_reg + 1'b1;
        window_hit = chain_match[PATTERN_BYTES] && (len_eff != '0)
                     && (int'(fill_inc) >= int'(len_eff));

        push_valid              = 1'b0;
        push_data.found         = 1'b0;
        push_data.match_address = '0;
        if (shift_en)
        begin
            if (window_hit)
            begin
                push_valid              = 1'b1;
                push_data.found         = 1'b1;
                push_data.match_address = base_address_reg + position_reg
                                          - sbs_pkg::SBS_ADDR_W'(addr_offset);
            end
            else if (in_data.last_byte)
            begin
                push_valid = 1'b1;
            end
        end

        position_next = position_reg;
        fill_next     = fill_reg;
        reported_next = reported_reg;
        if (accept)
        begin
            if (in_data.last_byte)
            begin
                position_next = '0;
                fill_next     = '0;
                reported_next = 1'b0;
            end
            else
            begin
                position_next = position_reg + 1'b1;
                if (shift_en)
                begin
                    fill_next     = fill_inc;
                    reported_next = window_hit;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            fill_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            position_reg <= position_next;
            fill_reg     <= fill_next;
            reported_reg <= reported_next;
        end
    end

    // output register with skid entry
    sbs_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .can_push   (can_push),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign in_ready = can_push;

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench of wildcard_byte_signature_scan
// predicts each scan report from its own model of the byte window and checks it
// depends on sbs_pkg and wildcard_byte_signature_scan
module tb_top;
    import sbs_pkg::*;

    localparam int WINDOW      = PATTERN_BYTES_DEF;
    localparam int CYCLE_LIMIT = 200000;

    // index values with no register behind them
    localparam logic [SBS_CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [SBS_CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    sbs_in_t                  in_data;
    logic                     out_valid;
    logic                     out_ready;
    sbs_out_t                 out_data;
    logic                     cfg_we;
    logic [SBS_CFG_IDX_W-1:0] cfg_index;
    logic [SBS_CFG_W-1:0]     cfg_data;

    // signature settings as last written
    logic [63:0]             sig_lo;
    logic [63:0]             sig_hi;
    logic [15:0]             sig_care;
    logic [SBS_LEN_W-1:0]    sig_len;
    logic [SBS_SKIP_W-1:0]   sig_skip;
    logic [SBS_ADDR_W-1:0]   range_base;

    // scan state of the current range
    logic [7:0]              scan_window [WINDOW];
    logic [SBS_ADDR_W-1:0]   range_offset;
    int                      window_fill;
    logic                    range_reported;

    sbs_out_t                reports_due [$];
    sbs_out_t                report_seen;
    int                      error_count;
    int                      cycle_count;
    int                      send_idle_pct;
    int                      recv_stall_pct;
    int                      receiver_hold;

    wildcard_byte_signature_scan DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** wildcard_byte_signature_scan: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (receiver_hold > 0)
        begin
            out_ready <= 1'b0;
            receiver_hold--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare every output transaction with the oldest pending report
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (reports_due.size() == 0)
            begin
                $error("unexpected report: found=%0b match_address=%h",
                       out_data.found, out_data.match_address);
                error_count++;
            end
            else
            begin
                report_seen = reports_due.pop_front();
                if (out_data.found !== report_seen.found)
                begin
                    $error("found: expected %0b, actual %0b",
                           report_seen.found, out_data.found);
                    error_count++;
                end
                if (out_data.match_address !== report_seen.match_address)
                begin
                    $error("match_address: expected %h, actual %h",
                           report_seen.match_address, out_data.match_address);
                    error_count++;
                end
            end
        end
    end

    // start of a new range
    function automatic void clear_range();
        int i;
        for (i = 0; i < WINDOW; i++)
            scan_window[i] = 8'h00;
        range_offset   = '0;
        window_fill    = 0;
        range_reported = 1'b0;
    endfunction

    // pattern length after saturation to the window depth
    function automatic int active_length();
        return (sig_len > WINDOW) ? WINDOW : int'(sig_len);
    endfunction

    // shift one byte into the window and queue the report it causes, if any
    function automatic void predict_scan_step(input logic [7:0] data, input logic last);
        int           len;
        int           i;
        logic [127:0] pat;
        logic         hit;
        sbs_out_t     rpt;
        if (!range_reported)
        begin
            for (i = WINDOW - 1; i > 0; i--)
                scan_window[i] = scan_window[i-1];
            scan_window[0] = data;
            if (window_fill < WINDOW)
                window_fill++;
            len = active_length();
            pat = {sig_hi, sig_lo};
            hit = (len != 0) && (window_fill >= len);
            for (i = 0; i < len; i++)
            begin
                if (sig_care[i] && scan_window[len-1-i] != pat[8*i +: 8])
                    hit = 1'b0;
            end
            if (hit)
            begin
                rpt.found         = 1'b1;
                rpt.match_address = range_base + range_offset - SBS_ADDR_W'(len - 1)
                                    - SBS_ADDR_W'(sig_skip);
                reports_due = {reports_due, rpt};
                range_reported = 1'b1;
            end
            else if (last)
            begin
                rpt.found         = 1'b0;
                rpt.match_address = '0;
                reports_due = {reports_due, rpt};
            end
        end
        range_offset = range_offset + 1'b1;
        if (last)
            clear_range();
    endfunction

    // one register write, mirrored into the predictor settings
    task automatic write_reg(input logic [SBS_CFG_IDX_W-1:0] idx,
                             input logic [SBS_CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_PATTERN_LOW:    sig_lo     = val;
            CFG_PATTERN_HIGH:   sig_hi     = val;
            CFG_CARE_MASK:      sig_care   = val[15:0];
            CFG_PATTERN_LENGTH: sig_len    = val[SBS_LEN_W-1:0];
            CFG_LEAD_SKIPS:     sig_skip   = val[SBS_SKIP_W-1:0];
            CFG_BASE_ADDRESS:   range_base = val[SBS_ADDR_W-1:0];
            default:            ;
        endcase
    endtask

    // offer one byte until taken, then maybe leave a gap
    task automatic send_byte(input logic [7:0] data, input logic last);
        sbs_in_t item;
        item.data_byte = data;
        item.last_byte = last;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_scan_step(data, last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // stop sending and wait until every pending report is in
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // new random signature, biased toward short patterns and edge values
    task automatic randomize_signature();
        logic [63:0] r;
        int          k;
        r = {$urandom, $urandom};
        if ($urandom_range(7) == 0)
            r = '0;
        write_reg(CFG_PATTERN_LOW, r);
        r = {$urandom, $urandom};
        if ($urandom_range(7) == 0)
            r = '1;
        write_reg(CFG_PATTERN_HIGH, r);
        r = {$urandom, $urandom};
        case ($urandom_range(7))
            0:       r[15:0] = 16'h0000;
            1, 2, 3: r[15:0] = 16'hFFFF;
            4:       r[15:0] = r[15:0] & 16'($urandom);
            default: ;
        endcase
        write_reg(CFG_CARE_MASK, r);
        r = {$urandom, $urandom};
        k = $urandom_range(19);
        if (k == 0)
            r[4:0] = 5'd0;
        else if (k == 1)
            r[4:0] = 5'd16;
        else if (k == 2)
            r[4:0] = 5'($urandom_range(17, 31));
        else if (k < 6)
            r[4:0] = 5'($urandom_range(7, 15));
        else
            r[4:0] = 5'($urandom_range(1, 6));
        write_reg(CFG_PATTERN_LENGTH, r);
        write_reg(CFG_LEAD_SKIPS, {$urandom, $urandom});
        r = {$urandom, $urandom};
        k = $urandom_range(9);
        if (k == 0)
            r[47:0] = '0;
        else if (k == 1)
            r[47:0] = '1;
        write_reg(CFG_BASE_ADDRESS, r);
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7, {$urandom, $urandom});
    endtask

    // directed cases: defaults, overlap, wrap, last-byte match, zero and oversized length
    task automatic test_directed_cases();
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // reset settings: a full-length pattern cannot fit in one byte
        send_byte(8'h00, 1'b1);
        settle_pipeline();
        write_reg(CFG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FF00);
        write_reg(CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_CARE_MASK, 64'h0000_0000_0000_FFFF);
        write_reg(CFG_PATTERN_LENGTH, 64'd2);
        write_reg(CFG_LEAD_SKIPS, 64'd15);
        write_reg(CFG_BASE_ADDRESS, 64'd0);
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, '1);
        // overlapping start, address wraps below zero, tail after the match ignored
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // range shorter than the pattern
        send_byte(8'hFF, 1'b1);
        // match on the last byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle_pipeline();
        // zero length never matches; upper data bits dropped
        write_reg(CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
        write_reg(CFG_CARE_MASK, 64'hFFFF_FFFF_FFFF_0000);
        send_byte(8'hAA, 1'b1);
        settle_pipeline();
        // oversized length saturates; all wildcards at the top of the address space
        write_reg(CFG_PATTERN_LENGTH, 64'd31);
        write_reg(CFG_LEAD_SKIPS, 64'd0);
        write_reg(CFG_BASE_ADDRESS, '1);
        for (i = 0; i < WINDOW; i++)
            send_byte(8'($urandom), i == WINDOW - 1);
        settle_pipeline();
    endtask

    // receiver holds off so the block fills, then the sender waits for every report
    task automatic test_backpressure_fill();
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_PATTERN_LENGTH, 64'd1);
        write_reg(CFG_CARE_MASK, 64'd0);
        write_reg(CFG_LEAD_SKIPS, 64'd3);
        write_reg(CFG_BASE_ADDRESS, 64'h0000_0000_0000_1000);
        receiver_hold = 80;
        for (i = 0; i < 24; i++)
            send_byte(8'($urandom), 1'b1);
        settle_pipeline();
        for (i = 0; i < 8; i++)
            send_byte(8'($urandom), $urandom_range(1));
        send_byte(8'($urandom), 1'b1);
        settle_pipeline();
    endtask

    // random ranges, most with the signature planted somewhere in them
    task automatic test_random_ranges(input int idle_pct, input int stall_pct,
                                      input int item_budget);
        int           sent;
        int           ranges;
        int           span;
        int           off;
        int           len;
        int           i;
        logic [127:0] pat;
        logic [7:0]   range_bytes [$];
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent   = 0;
        ranges = 0;
        while (sent < item_budget)
        begin
            if (ranges % 6 == 0)
            begin
                settle_pipeline();
                randomize_signature();
            end
            len = active_length();
            pat = {sig_hi, sig_lo};
            case ($urandom_range(9))
                0:       span = 1;
                1, 2:    span = $urandom_range(25, 48);
                default: span = $urandom_range(1, 24);
            endcase
            // random content with many near-miss pattern bytes
            range_bytes.delete();
            for (i = 0; i < span; i++)
                range_bytes = {range_bytes,
                               ($urandom_range(1) ? pat[8*$urandom_range(15) +: 8]
                                                  : 8'($urandom))};
            // plant the signature, now and then broken in its last byte
            if (len > 0 && span >= len && $urandom_range(9) < 6)
            begin
                off = $urandom_range(span - len);
                for (i = 0; i < len; i++)
                begin
                    if (sig_care[i])
                        range_bytes[off+i] = pat[8*i +: 8];
                end
                if ($urandom_range(9) == 0)
                    range_bytes[off+len-1] = range_bytes[off+len-1] ^ 8'h01;
            end
            for (i = 0; i < span; i++)
                send_byte(range_bytes[i], i == span - 1);
            sent += span;
            ranges++;
            if ($urandom_range(19) == 0)
                settle_pipeline();
        end
        settle_pipeline();
    endtask

    // test sequence
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        receiver_hold  = 0;
        sig_lo         = '0;
        sig_hi         = '0;
        sig_care       = SBS_CARE_RST;
        sig_len        = SBS_LEN_RST;
        sig_skip       = '0;
        range_base     = '0;
        clear_range();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_backpressure_fill();
        test_random_ranges(0, 0, 320);
        test_random_ranges(58, 0, 320);
        test_random_ranges(0, 58, 320);
        test_random_ranges(31, 31, 320);
        settle_pipeline();

        if (error_count == 0)
            $display("** wildcard_byte_signature_scan: PASSED **");
        else
            $display("** wildcard_byte_signature_scan: FAILED **");
        $finish;
    end

endmodule
